### rtl/hufd_pkg.sv
// hufd_pkg: shared types and constants of the table driven huffman bit decoder
`default_nettype none

package hufd_pkg;

	localparam int TABLE_DEPTH   = 16;
	localparam int MAX_CODE_BITS = 16;
	localparam int BYTE_BITS     = 8;
	localparam int QDEPTH        = 4;

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
	localparam int CMP_W  = (MAX_CODE_BITS > 16) ? MAX_CODE_BITS : 16;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef struct packed {
		logic        operation;
		logic        message_start;
		logic [7:0]  data_byte;
		logic [3:0]  bit_count;
		logic [3:0]  entry_index;
		logic [7:0]  entry_symbol;
		logic [4:0]  entry_length;
		logic [15:0] entry_code;
	} in_item_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
		logic       code_error;
	} out_item_t;

	typedef struct packed {
		logic             is_load;
		logic             start;
		logic [7:0]       data;
		logic [3:0]       count;
		logic [IDX_W-1:0] idx;
		logic [7:0]       symbol;
		logic [4:0]       length;
		logic [15:0]      code;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/hufd_front.sv
// hufd_front: accepts items, classifies them and queues them for the decode engine
`default_nettype none

module hufd_front
	import hufd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire in_item_t cmd,
	output logic          head_valid,
	output cmd_t          head,
	input  wire logic     head_pop
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cls;
	logic              in_range;
	logic              full;
	logic              xfer;
	logic              push;
	logic              pop;

	// classify the incoming item
	always_comb begin
		in_range    = 32'(cmd.entry_index) < TABLE_DEPTH;
		cls.is_load = (cmd.operation == OP_LOAD);
		cls.start   = cmd.message_start;
		cls.data    = cmd.data_byte;
		cls.count   = (cmd.bit_count > 4'(BYTE_BITS)) ? 4'(BYTE_BITS) : cmd.bit_count;
		cls.idx     = IDX_W'(cmd.entry_index);
		cls.symbol  = cmd.entry_symbol;
		cls.length  = cmd.entry_length;
		cls.code    = cmd.entry_code;
	end

	assign full       = (32'(count_q) == QDEPTH);
	assign cmd_stall  = full;
	assign xfer       = cmd_valid && !full;
	// out of range loads are dropped here
	assign push       = xfer && !(cls.is_load && !in_range);
	assign head_valid = (count_q != '0);
	assign pop        = head_pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= QCNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= QCNT_W'(count_q - 1'b1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= QDEPTH)
		else $error("queue count above depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (32'(count_q) == 32'($past(count_q)) + 1))
		else $error("queue count did not rise on push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (32'(count_q) + 1 == 32'($past(count_q))))
		else $error("queue count did not fall on pop");
`endif

endmodule

`default_nettype wire

### rtl/hufd_back.sv
// hufd_back: code table, bit serial accumulator with parallel table match, result register
`default_nettype none

module hufd_back
	import hufd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire cmd_t head,
	output logic      head_pop,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output out_item_t rsp
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SHIFT = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	localparam int ACC_W = MAX_CODE_BITS;

	state_t           state_q;
	logic [7:0]       sym_q   [TABLE_DEPTH];
	logic [4:0]       tlen_q  [TABLE_DEPTH];
	logic [15:0]      tcode_q [TABLE_DEPTH];
	logic [ACC_W-1:0] acc_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       data_q;
	logic [3:0]       left_q;
	logic             pend_valid_q;
	logic [7:0]       pend_sym_q;
	logic             pend_err_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [ACC_W-1:0] acc_n;
	logic [LEN_W-1:0] len_n;
	logic             hit;
	logic [7:0]       hit_sym;
	logic             over;
	logic             emit;
	logic             out_free;
	logic             step;
	logic             flush;
	logic             push_out;
	out_item_t        push_item;

	assign acc_n = ACC_W'({acc_q, data_q[7]});
	assign len_n = LEN_W'(len_q + 1'b1);

	// first live entry matching length and code; a zero symbol ends the table
	always_comb begin
		logic alive;
		alive   = 1'b1;
		hit     = 1'b0;
		hit_sym = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			alive = alive && (sym_q[k] != '0);
			if (!hit && alive && (32'(tlen_q[k]) == 32'(len_n))
					&& (CMP_W'(tcode_q[k]) == CMP_W'(acc_n))) begin
				hit     = 1'b1;
				hit_sym = sym_q[k];
			end
		end
	end

	assign over     = 32'(len_n) >= MAX_CODE_BITS;
	assign emit     = hit || over;
	assign out_free = !out_valid_q || !rsp_stall;
	assign head_pop = (state_q == ST_IDLE) && head_valid;
	assign step     = (state_q == ST_SHIFT) && out_free;
	assign flush    = (state_q == ST_FLUSH) && out_free;
	assign push_out = pend_valid_q && ((step && emit) || flush);

	always_comb begin
		push_item.symbol     = pend_sym_q;
		push_item.last       = flush;
		push_item.code_error = pend_err_q;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// table contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				sym_q[k] <= '0;
			end
		end else if (head_pop && head.is_load) begin
			sym_q[head.idx] <= head.symbol;
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop && head.is_load) begin
			tlen_q[head.idx]  <= head.length;
			tcode_q[head.idx] <= head.code;
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			out_q <= push_item;
		end
		if (step && emit) begin
			pend_sym_q <= hit ? hit_sym : 8'd0;
			pend_err_q <= !hit;
		end
		if (head_pop && !head.is_load) begin
			data_q <= head.data;
		end else if (step) begin
			data_q <= {data_q[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			acc_q        <= '0;
			len_q        <= '0;
			left_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head_pop && !head.is_load) begin
						if (head.start) begin
							acc_q <= '0;
							len_q <= '0;
						end
						left_q <= head.count;
						if (head.count != '0) begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (step) begin
						if (emit) begin
							acc_q        <= '0;
							len_q        <= '0;
							pend_valid_q <= 1'b1;
						end else begin
							acc_q <= acc_n;
							len_q <= len_n;
						end
						left_q <= 4'(left_q - 4'd1);
						if (left_q == 4'd1) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (flush) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held result left over in idle");
	a_shift_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (left_q != '0))
		else $error("shifting with no bits left");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(len_q) < MAX_CODE_BITS)
		else $error("accumulated length reached maximum");
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(flush && pend_valid_q) |=> (out_valid_q && out_q.last))
		else $error("final result of byte not marked last");
`endif

endmodule

`default_nettype wire

### rtl/huffman_table_bit_decoder_top.sv
// huffman_table_bit_decoder_top: queued front end feeding the table driven bit decoder
// an accepted item is written into a four entry queue and is picked up when the decoder is idle
// a load or a zero count decode is done at pick up; a decode of n bits steps through:
// pick up in idle, one bit per cycle through the all-entries compare in shift, then flush to release the last
// result; output stalls hold the bit steps; a result waits for the next one or the byte end
// reset: table symbols cleared (empty table), accumulator and queue empty, no clearing pass
`default_nettype none

module huffman_table_bit_decoder_top
	import hufd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire in_item_t cmd,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output out_item_t     rsp
);

	logic head_valid;
	cmd_t head;
	logic head_pop;

	hufd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	hufd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire
